### rtl/sfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame receiver.
package sfr_pkg;

    // Frame delimiters and report selectors
    localparam logic [7:0]  START_FIRST  = 8'h05;
    localparam logic [7:0]  START_SECOND = 8'h64;
    localparam logic [7:0]  ID_SENSORS   = 8'h01;
    localparam logic [7:0]  ID_RELAYS    = 8'h02;

    // CRC-16, polynomial 3D65h, MSB first
    localparam logic [15:0] CRC_POLY     = 16'h3D65;
    localparam logic [15:0] CRC_TOP      = 16'h8000;

    // Report content byte positions, byte count limit, header length
    localparam logic [8:0]  IDX_ID       = 9'd4;
    localparam logic [8:0]  IDX_VALUE    = 9'd6;
    localparam logic [8:0]  COUNT_MAX    = 9'd511;
    localparam logic [8:0]  HEADER_LEN   = 9'd4;

    // Report kinds
    localparam logic        KIND_SENSOR  = 1'b0;
    localparam logic        KIND_RELAY   = 1'b1;

    localparam logic [7:0]  MASK_ALL     = 8'hFF;

    typedef enum logic [2:0] {
        PH_START1,
        PH_START2,
        PH_SIZE,
        PH_CONTROL,
        PH_DATA,
        PH_CRC1,
        PH_CRC2
    } phase_t;

    // One queued report request
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } report_t;

    // Feed one byte into the running CRC, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/sfr_front.sv
// Front end: frame parser with running CRC check; queues reports of good frames.
module sfr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      rx_byte,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            q_full,
    output logic            push,
    output sfr_pkg::report_t push_data
);
    import sfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [8:0]  frame_end_reg, frame_end_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [7:0]  frame_value_reg, frame_value_next;

    logic        accept;
    logic        take;
    logic        crc_good;
    logic [8:0]  bc_base;
    logic [8:0]  bc_inc;
    logic [15:0] crc_in;
    logic [7:0]  crc_byte;
    logic [15:0] crc_calc;

    // Hold the line while the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Byte index and CRC input; a new frame restarts both
    assign bc_base  = (phase_reg == PH_START1) ? 9'd0 : byte_count_reg;
    assign bc_inc   = (bc_base < COUNT_MAX) ? bc_base + 9'd1 : bc_base;
    assign crc_in   = (phase_reg == PH_START1) ? 16'h0000 : crc_reg;
    assign crc_byte = (phase_reg == PH_CRC1 || phase_reg == PH_CRC2) ? 8'h00 : rx_byte;
    assign crc_calc = crc_feed(crc_in, crc_byte);
    assign crc_good = (crc_calc == {crc_high_reg, rx_byte});

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_START1:
                begin
                    if (rx_byte == START_FIRST)
                        phase_next = PH_START2;
                end
                PH_START2:
                begin
                    if (rx_byte == START_SECOND)
                        phase_next = PH_SIZE;
                    else
                        phase_next = PH_START1;
                end
                PH_SIZE:    phase_next = PH_CONTROL;
                PH_CONTROL: phase_next = PH_DATA;
                PH_DATA:
                begin
                    if (bc_inc >= frame_end_reg)
                        phase_next = PH_CRC1;
                end
                PH_CRC1:    phase_next = PH_CRC2;
                PH_CRC2:    phase_next = PH_START1;
                default:    phase_next = PH_START1;
            endcase
        end
    end

    // Decide whether this beat belongs to the frame
    always_comb
    begin
        unique case (phase_reg)
            PH_START1: take = (rx_byte == START_FIRST);
            PH_START2: take = (rx_byte == START_SECOND);
            default:   take = 1'b1;
        endcase
    end

    // Datapath updates and report push
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        frame_end_next   = frame_end_reg;
        crc_high_next    = crc_high_reg;
        frame_id_next    = frame_id_reg;
        frame_value_next = frame_value_reg;
        push             = 1'b0;
        if (accept && take)
        begin
            byte_count_next = bc_inc;
            crc_next        = crc_calc;
            if (bc_base == IDX_ID)
                frame_id_next = rx_byte;
            if (bc_base == IDX_VALUE)
                frame_value_next = rx_byte;
            if (phase_reg == PH_SIZE)
                frame_end_next = {1'b0, rx_byte} + HEADER_LEN;
            if (phase_reg == PH_CRC1)
                crc_high_next = rx_byte;
            if (phase_reg == PH_CRC2 && crc_good &&
                (frame_id_next == ID_SENSORS || frame_id_next == ID_RELAYS))
                push = 1'b1;
        end
        push_data.kind  = (frame_id_next == ID_RELAYS) ? KIND_RELAY : KIND_SENSOR;
        push_data.value = frame_value_next;
    end

    // Parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START1;
            frame_end_reg   <= 9'd0;
            byte_count_reg  <= 9'd0;
            crc_reg         <= 16'h0000;
            crc_high_reg    <= 8'h00;
            frame_id_reg    <= 8'h00;
            frame_value_reg <= 8'h00;
        end
        else
        begin
            phase_reg       <= phase_next;
            frame_end_reg   <= frame_end_next;
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
            crc_high_reg    <= crc_high_next;
            frame_id_reg    <= frame_id_next;
            frame_value_reg <= frame_value_next;
        end
    end

endmodule

### rtl/sfr_queue.sv
// Small FIFO of report requests between the parser and the report stage.
module sfr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfr_pkg::report_t push_data,
    output logic             full,
    output logic             pop_valid,
    output sfr_pkg::report_t pop_data,
    input  logic             pop
);
    import sfr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    report_t        entries [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/sfr_back.sv
// Back end: builds the change mask, keeps sensor history, drives the output register.
module sfr_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  sfr_pkg::report_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             report_kind,
    output logic [7:0]       state_value,
    output logic [7:0]       changed_mask
);
    import sfr_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic       kind_reg, kind_next;
    logic [7:0] value_reg, value_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] last_sensors_reg, last_sensors_next;
    logic       first_report_reg, first_report_next;

    // Take a request whenever the output register is free or draining
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    // Build the next beat and update sensor history
    always_comb
    begin
        out_valid_next    = out_valid_reg && out_stall;
        kind_next         = kind_reg;
        value_next        = value_reg;
        mask_next         = mask_reg;
        last_sensors_next = last_sensors_reg;
        first_report_next = first_report_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            kind_next      = q_data.kind;
            value_next     = q_data.value;
            if (q_data.kind == KIND_SENSOR)
            begin
                mask_next         = first_report_reg ? MASK_ALL
                                                     : (last_sensors_reg ^ q_data.value);
                last_sensors_next = q_data.value;
                first_report_next = 1'b0;
            end
            else
            begin
                mask_next = MASK_ALL;
            end
        end
    end

    // Control and history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            last_sensors_reg <= 8'h00;
            first_report_reg <= 1'b1;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            last_sensors_reg <= last_sensors_next;
            first_report_reg <= first_report_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        mask_reg  <= mask_next;
    end

    assign out_valid    = out_valid_reg;
    assign report_kind  = kind_reg;
    assign state_value  = value_reg;
    assign changed_mask = mask_reg;

endmodule

### rtl/serial_frame_receiver_crc16_report.sv
// Frame receiver: takes one byte per cycle, hunting for the 05h 64h start pair, then
// size, control, max(size,1) data bytes and two CRC bytes checked against a CRC-16
// (polynomial 3D65h, zero start, augmented). A good frame with id 01h gives a sensor
// report with a mask of changed bits (all ones on the first one); id 02h gives a relay
// report. A byte is taken every cycle; the parser stalls only when QUEUE_DEPTH reports
// wait in the queue behind a stalled output register. After the last CRC byte, a report
// is written into the queue and then into the output register before it appears.
module serial_frame_receiver_crc16_report
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       report_kind,
    output logic [7:0] state_value,
    output logic [7:0] changed_mask,
    output logic       out_valid,
    input  logic       out_stall
);
    import sfr_pkg::*;

    logic    q_full;
    logic    q_push;
    report_t q_push_data;
    logic    q_valid;
    report_t q_data;
    logic    q_pop;

    // Parse and check frames
    sfr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Buffer report requests
    sfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .pop       (q_pop)
    );

    // Build and deliver reports
    sfr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .report_kind  (report_kind),
        .state_value  (state_value),
        .changed_mask (changed_mask)
    );

endmodule
